### rtl/rsr_pkg.sv
// Shared types and constants for the rotating substitution rotor.
package rsr_pkg;

  localparam int unsigned MaxSymbolsDef = 32;
  localparam int unsigned SizeW         = 6;
  localparam int unsigned CharW         = 8;
  localparam int unsigned EntryW        = 5;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned SizeReset     = 26;
  localparam int unsigned SizeMin       = 2;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SETPOS = 2'd1,
    ACT_STEP   = 2'd2,
    ACT_CIPHER = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

endpackage

### rtl/rsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rotating_substitution_rotor.sv
// One cipher rotor: alphabet and wiring tables, position counter, step and substitute.
//
// Load and set-position commands finish at once: busy stays low and the result beat
// appears on the next cycle. A cipher command scans the alphabet table one entry per
// cycle through its single read port; a hit fetches the matching wiring entry as the
// result, a miss after the last of n entries gives status miss (n is the alphabet size
// in use). A step command first reduces position+1 modulo n with a shift-subtract unit,
// one quotient bit per cycle, then rotates the wiring table through its one read and
// one write port, one entry per cycle. The result beat is shown for one cycle
// on valid_o and cannot be held off, so the receiver must take it.
module rotating_substitution_rotor #(
  parameter int unsigned MAX_SYMBOLS = rsr_pkg::MaxSymbolsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rsr_pkg::SizeW-1:0]    cfg_wdata_i,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action_i,
  input  logic [rsr_pkg::EntryW-1:0]   entry_index_i,
  input  logic [rsr_pkg::CharW-1:0]    alphabet_char_i,
  input  logic [rsr_pkg::CharW-1:0]    wired_char_i,
  input  logic [rsr_pkg::EntryW-1:0]   start_position_i,
  input  logic [rsr_pkg::CharW-1:0]    symbol_in_i,
  output logic                         valid_o,
  output logic [rsr_pkg::CharW-1:0]    symbol_out_o,
  output logic [rsr_pkg::StatusW-1:0]  status_o,
  output logic                         carry_o
);

  localparam int unsigned Cap = (MAX_SYMBOLS < 32) ? MAX_SYMBOLS : 32;
  localparam int unsigned IW  = $clog2(Cap);
  localparam int unsigned RW  = IW + 1;
  localparam int unsigned SHW = $clog2(IW + 1);
  localparam int unsigned DW  = rsr_pkg::SizeW + IW;
  localparam int unsigned SW  = rsr_pkg::SizeW;
  localparam int unsigned CW  = rsr_pkg::CharW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_FETCH,
    S_MOD,
    S_ROT_LAST,
    S_ROT,
    S_ROT_END
  } state_e;

  state_e                   state_q, state_d;
  logic [SW-1:0]            size_q, size_d;
  logic [IW-1:0]            position_q, position_d;
  logic                     valid_q, valid_d;
  logic [CW-1:0]            symbol_out_q, symbol_out_d;
  rsr_pkg::status_e         status_q, status_d;
  logic                     carry_q, carry_d;
  logic                     wrap_q, wrap_d;

  logic [IW-1:0]            idx_q, idx_d;
  logic [RW-1:0]            rem_q, rem_d;
  logic [SHW-1:0]           sh_q, sh_d;
  logic [CW-1:0]            sym_q, sym_d;
  logic [CW-1:0]            last_q, last_d;

  logic [SW-1:0]            n;
  logic [IW-1:0]            n_m1;
  logic [DW-1:0]            dvs;
  logic [DW-1:0]            rem_ext;
  logic [RW-1:0]            rem_sub;

  logic                     alpha_we;
  logic [IW-1:0]            alpha_raddr;
  logic [CW-1:0]            alpha_rdata;
  logic                     wire_we;
  logic [IW-1:0]            wire_waddr;
  logic [CW-1:0]            wire_wdata;
  logic [IW-1:0]            wire_raddr;
  logic [CW-1:0]            wire_rdata;
  logic                     accept;

  // Clamp the configured size between the minimum size and the table depth.
  always_comb begin
    if (size_q < SW'(rsr_pkg::SizeMin)) begin
      n = SW'(rsr_pkg::SizeMin);
    end else if (size_q > SW'(Cap)) begin
      n = SW'(Cap);
    end else begin
      n = size_q;
    end
  end

  assign n_m1    = IW'(n - SW'(1));
  assign dvs     = DW'(n) << sh_q;
  assign rem_ext = DW'(rem_q);
  assign rem_sub = (rem_ext >= dvs) ? RW'(rem_ext - dvs) : rem_q;
  assign accept  = start && (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    size_d       = cfg_we_i ? cfg_wdata_i : size_q;
    position_d   = position_q;
    valid_d      = 1'b0;
    symbol_out_d = '0;
    status_d     = rsr_pkg::ST_OK;
    carry_d      = 1'b0;
    wrap_d       = wrap_q;
    idx_d        = idx_q;
    rem_d        = rem_q;
    sh_d         = sh_q;
    sym_d        = sym_q;
    last_d       = last_q;
    alpha_we     = 1'b0;
    alpha_raddr  = '0;
    wire_we      = 1'b0;
    wire_waddr   = entry_index_i[IW-1:0];
    wire_wdata   = wired_char_i;
    wire_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (rsr_pkg::action_e'(action_i))
            rsr_pkg::ACT_LOAD: begin
              valid_d = 1'b1;
              if ({1'b0, entry_index_i} < (rsr_pkg::EntryW + 1)'(Cap)) begin
                alpha_we = 1'b1;
                wire_we  = 1'b1;
              end else begin
                status_d = rsr_pkg::ST_RANGE;
              end
            end
            rsr_pkg::ACT_SETPOS: begin
              valid_d = 1'b1;
              if (SW'(start_position_i) < n) begin
                position_d = start_position_i[IW-1:0];
              end else begin
                status_d = rsr_pkg::ST_RANGE;
              end
            end
            rsr_pkg::ACT_STEP: begin
              rem_d   = RW'(position_q) + RW'(1);
              sh_d    = SHW'(IW - 1);
              state_d = S_MOD;
            end
            rsr_pkg::ACT_CIPHER: begin
              sym_d       = symbol_in_i;
              idx_d       = '0;
              alpha_raddr = '0;
              state_d     = S_SEARCH;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (alpha_rdata == sym_q) begin
          wire_raddr = idx_q;
          state_d    = S_FETCH;
        end else if (idx_q == n_m1) begin
          valid_d  = 1'b1;
          status_d = rsr_pkg::ST_MISS;
          state_d  = S_IDLE;
        end else begin
          idx_d       = idx_q + IW'(1);
          alpha_raddr = idx_q + IW'(1);
        end
      end
      S_FETCH: begin
        valid_d      = 1'b1;
        symbol_out_d = wire_rdata;
        state_d      = S_IDLE;
      end
      S_MOD: begin
        // Restoring reduction, one quotient bit per cycle.
        rem_d = rem_sub;
        if (sh_q == '0) begin
          position_d = rem_sub[IW-1:0];
          wrap_d     = (rem_sub == '0);
          idx_d      = n_m1;
          wire_raddr = n_m1;
          state_d    = S_ROT_LAST;
        end else begin
          sh_d = sh_q - SHW'(1);
        end
      end
      S_ROT_LAST: begin
        // Hold the top entry; it wraps around to slot zero.
        last_d     = wire_rdata;
        wire_raddr = idx_q - IW'(1);
        state_d    = S_ROT;
      end
      S_ROT: begin
        wire_we    = 1'b1;
        wire_waddr = idx_q;
        wire_wdata = wire_rdata;
        if (idx_q == IW'(1)) begin
          state_d = S_ROT_END;
        end else begin
          idx_d      = idx_q - IW'(1);
          wire_raddr = idx_q - IW'(2);
        end
      end
      S_ROT_END: begin
        wire_we    = 1'b1;
        wire_waddr = '0;
        wire_wdata = last_q;
        valid_d    = 1'b1;
        carry_d    = wrap_q;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      size_q       <= SW'(rsr_pkg::SizeReset);
      position_q   <= '0;
      valid_q      <= 1'b0;
      symbol_out_q <= '0;
      status_q     <= rsr_pkg::ST_OK;
      carry_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      size_q       <= size_d;
      position_q   <= position_d;
      valid_q      <= valid_d;
      symbol_out_q <= symbol_out_d;
      status_q     <= status_d;
      carry_q      <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wrap_q <= wrap_d;
    idx_q  <= idx_d;
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    sym_q  <= sym_d;
    last_q <= last_d;
  end

  rsr_ram #(
    .WIDTH (CW),
    .DEPTH (Cap)
  ) u_alpha_ram (
    .clk_i   (clk_i),
    .we_i    (alpha_we),
    .waddr_i (entry_index_i[IW-1:0]),
    .wdata_i (alphabet_char_i),
    .raddr_i (alpha_raddr),
    .rdata_o (alpha_rdata)
  );

  rsr_ram #(
    .WIDTH (CW),
    .DEPTH (Cap)
  ) u_wire_ram (
    .clk_i   (clk_i),
    .we_i    (wire_we),
    .waddr_i (wire_waddr),
    .wdata_i (wire_wdata),
    .raddr_i (wire_raddr),
    .rdata_o (wire_rdata)
  );

  assign busy         = (state_q != S_IDLE);
  assign valid_o      = valid_q;
  assign symbol_out_o = symbol_out_q;
  assign status_o     = status_q;
  assign carry_o      = carry_q;

  // A result beat only leaves once the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy)
    else $error("result beat while sequencer busy");

  // Every accepted command either starts the sequencer or answers at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || valid_o))
    else $error("accepted command dropped");

  // Carry only comes with a clean step result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    carry_o |-> (valid_o && status_o == rsr_pkg::ST_OK && symbol_out_o == '0))
    else $error("carry on a non-step result");

  // A stepped position stays below the alphabet size in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT_END) |-> (SW'(position_q) < n))
    else $error("stepped position not reduced");

endmodule
